// File: hw/rtl/heat_diffusion_stencil_defines.svh
// Assertion macros for the heat diffusion stencil checker.
`ifndef HEAT_DIFFUSION_STENCIL_DEFINES_SVH
`define HEAT_DIFFUSION_STENCIL_DEFINES_SVH

// Check post in the same cycle as pre.
`define HDS_ASSERT_SAME(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Check post in the cycle after pre.
`define HDS_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// File: hw/rtl/hds_pkg.sv
// Types and constants shared by the heat diffusion stencil files.
package hds_pkg;

   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 16;
   localparam int GRID_WIDTH_BITS = 11;
   localparam int ROW_BITS        = 16;
   localparam int COEF_BITS       = 16;
   localparam int FRAC_BITS       = 16;

   localparam logic [GRID_WIDTH_BITS-1:0] GRID_WIDTH_RESET  = 11'd1024;
   localparam logic [ROW_BITS-1:0]        GRID_HEIGHT_RESET = 16'd1024;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_GRID_WIDTH  = 2'd0,
      REG_GRID_HEIGHT = 2'd1,
      REG_COEF_X      = 2'd2,
      REG_COEF_Y      = 2'd3
   } csr_reg_type;

endpackage

// File: hw/rtl/heat_diffusion_stencil.sv
// Heat diffusion stencil: one explicit time step of the 2D heat equation.
//
// Usage:
//   req channel: grid temperatures (unsigned Q16.16) in raster order, one word per
//   transfer; tuser marks row 0 column 0 and restarts the position counters.
//   rsp channel: one word per interior point, emitted when the point below and right of it
//   arrives; tlast marks the final interior point. Boundary points give no word.
//   csr channel: register writes (0 width, 1 height, 2 coef_x, 3 coef_y), always
//   ready; write only while no word is in flight.
// Timing:
//   Four-stage pipeline (line buffer read, window shift, multiply, sum and
//   saturate); a result enters it when the word to its lower right is accepted.
//   One word is accepted every cycle while the receiver does not stall; the line
//   buffers are two RAMs, each read and written once per cycle, with a forward
//   path for back-to-back access to the same column.
// Reset clears the counters and all valid bits and loads the register defaults;
// the line buffers are not cleared. When the receiver stalls, the whole pipeline
// holds and req_tready drops in the same cycle.
module heat_diffusion_stencil import hds_pkg::*; #(
   parameter int MAX_WIDTH = 1024,
   parameter int TEMP_BITS = 32,
   localparam int COL_BITS      = $clog2(MAX_WIDTH),
   localparam int REQ_DATA_BITS = ((TEMP_BITS + 7) / 8) * 8,
   localparam int RSP_DATA_BITS = ((TEMP_BITS + ROW_BITS + COL_BITS + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,   // temperature
   input  logic                      req_tuser,   // first_point
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,   // new_temperature, out_row, out_col
   output logic                      rsp_tlast,   // last_point
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int WW   = (COL_BITS + 1 > GRID_WIDTH_BITS) ? COL_BITS + 1 : GRID_WIDTH_BITS;
   localparam int LW   = TEMP_BITS + 3;
   localparam int PROD = LW + COEF_BITS + 1;
   localparam int PW   = PROD - FRAC_BITS;
   localparam int SW   = LW + 3;

   // configuration
   logic [GRID_WIDTH_BITS-1:0] width_ff;
   logic [ROW_BITS-1:0]        height_ff;
   logic [COEF_BITS-1:0]       coef_x_ff;
   logic [COEF_BITS-1:0]       coef_y_ff;

   // position counters
   logic [COL_BITS-1:0] col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;

   // front-end decode
   logic [WW-1:0]       w_eff, gw, c_ext;
   logic [ROW_BITS-1:0] h_eff, r_cur;
   logic [COL_BITS-1:0] c_cur;
   logic                col_wrap, row_wrap, emit_in, last_in, enable, accept;

   // stage A: line buffer read
   logic                 a_valid_ff, a_emit_ff, a_last_ff, a_hit_ff;
   logic [TEMP_BITS-1:0] a_t_ff, rd0_ff, rd1_ff, fwd0_ff, fwd1_ff, eff0, eff1;
   logic [COL_BITS-1:0]  a_addr_ff, a_col_ff;
   logic [ROW_BITS-1:0]  a_row_ff;
   logic [TEMP_BITS-1:0] line0_mem [MAX_WIDTH];
   logic [TEMP_BITS-1:0] line1_mem [MAX_WIDTH];

   // stage B: window
   logic                 b_emit_ff, b_last_ff;
   logic [ROW_BITS-1:0]  b_row_ff;
   logic [COL_BITS-1:0]  b_col_ff;
   logic [TEMP_BITS-1:0] w0_1_ff, w0_2_ff, w1_0_ff, w1_1_ff, w1_2_ff, w2_1_ff, w2_2_ff;

   // stage C: products
   logic                    c_emit_ff, c_last_ff;
   logic [ROW_BITS-1:0]     c_row_ff;
   logic [COL_BITS-1:0]     c_col_ff;
   logic [TEMP_BITS-1:0]    c_ctr_ff;
   logic signed [PW-1:0]    c_px_ff, c_py_ff;
   logic signed [LW-1:0]    lapx, lapy;
   logic signed [COEF_BITS:0] kx, ky;
   logic signed [PROD-1:0]  px_full, py_full;

   // stage D: result
   logic signed [SW-1:0] sum;
   logic [TEMP_BITS-1:0] sat;
   logic                 rsp_valid_ff, rsp_last_ff;
   logic [TEMP_BITS-1:0] rsp_temp_ff;
   logic [ROW_BITS-1:0]  rsp_row_ff;
   logic [COL_BITS-1:0]  rsp_col_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= GRID_WIDTH_RESET;
         height_ff <= GRID_HEIGHT_RESET;
         coef_x_ff <= '0;
         coef_y_ff <= '0;
      end else if (csr_valid) begin
         case (csr_reg_type'(csr_index))
            REG_GRID_WIDTH:  width_ff  <= csr_data[GRID_WIDTH_BITS-1:0];
            REG_GRID_HEIGHT: height_ff <= csr_data[ROW_BITS-1:0];
            REG_COEF_X:      coef_x_ff <= csr_data[COEF_BITS-1:0];
            REG_COEF_Y:      coef_y_ff <= csr_data[COEF_BITS-1:0];
            default: ;
         endcase
      end
   end

   // clamp the grid size and decode the position of the incoming word
   always_comb begin
      gw = WW'(width_ff);
      if (gw < WW'(3)) begin
         w_eff = WW'(3);
      end else if (gw > WW'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = gw;
      end
      h_eff = (height_ff < ROW_BITS'(3)) ? ROW_BITS'(3) : height_ff;
      r_cur = req_tuser ? '0 : row_ff;
      c_cur = req_tuser ? '0 : col_ff;
      c_ext = WW'(c_cur);
      col_wrap = (c_ext + WW'(1)) >= w_eff;
      row_wrap = ((ROW_BITS + 1)'(r_cur) + (ROW_BITS + 1)'(1)) >= (ROW_BITS + 1)'(h_eff);
      col_in = col_wrap ? '0 : c_cur + COL_BITS'(1);
      if (!col_wrap) begin
         row_in = r_cur;
      end else if (row_wrap) begin
         row_in = '0;
      end else begin
         row_in = r_cur + ROW_BITS'(1);
      end
      emit_in = (r_cur >= ROW_BITS'(2)) && (r_cur < h_eff)
             && (c_ext >= WW'(2)) && (c_ext < w_eff);
      last_in = (r_cur == h_eff - ROW_BITS'(1)) && (c_ext == w_eff - WW'(1));
   end

   assign enable     = !rsp_valid_ff || rsp_tready;
   assign req_tready = enable;
   assign accept     = req_tvalid && enable;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         a_valid_ff   <= 1'b0;
         a_hit_ff     <= 1'b0;
         b_emit_ff    <= 1'b0;
         c_emit_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (enable) begin
            a_valid_ff   <= accept;
            // same column as the word being written back this cycle
            a_hit_ff     <= accept && a_valid_ff && (a_addr_ff == c_cur);
            b_emit_ff    <= a_valid_ff && a_emit_ff;
            c_emit_ff    <= b_emit_ff;
            rsp_valid_ff <= c_emit_ff;
         end
      end
   end

   // stage A payload and line buffers (read-first)
   always_ff @(posedge clock) begin
      if (accept) begin
         a_t_ff    <= req_tdata[TEMP_BITS-1:0];
         a_addr_ff <= c_cur;
         a_emit_ff <= emit_in;
         a_last_ff <= last_in;
         a_row_ff  <= r_cur - ROW_BITS'(1);
         a_col_ff  <= c_cur - COL_BITS'(1);
         rd0_ff    <= line0_mem[c_cur];
         rd1_ff    <= line1_mem[c_cur];
      end
      if (enable && a_valid_ff) begin
         line0_mem[a_addr_ff] <= eff1;
         line1_mem[a_addr_ff] <= a_t_ff;
      end
   end

   assign eff0 = a_hit_ff ? fwd0_ff : rd0_ff;
   assign eff1 = a_hit_ff ? fwd1_ff : rd1_ff;

   // stage B: shift the window, keep the written values for forwarding
   always_ff @(posedge clock) begin
      if (enable && a_valid_ff) begin
         fwd0_ff  <= eff1;
         fwd1_ff  <= a_t_ff;
         w0_1_ff  <= w0_2_ff;
         w0_2_ff  <= eff0;
         w1_0_ff  <= w1_1_ff;
         w1_1_ff  <= w1_2_ff;
         w1_2_ff  <= eff1;
         w2_1_ff  <= w2_2_ff;
         w2_2_ff  <= a_t_ff;
         b_row_ff <= a_row_ff;
         b_col_ff <= a_col_ff;
         b_last_ff <= a_last_ff;
      end
   end

   // stage C: Laplacian terms times coefficients, floor by dropping fraction bits
   always_comb begin
      lapx = $signed(LW'(w1_0_ff)) + $signed(LW'(w1_2_ff)) - ($signed(LW'(w1_1_ff)) <<< 1);
      lapy = $signed(LW'(w0_1_ff)) + $signed(LW'(w2_1_ff)) - ($signed(LW'(w1_1_ff)) <<< 1);
      kx = $signed({1'b0, coef_x_ff});
      ky = $signed({1'b0, coef_y_ff});
      px_full = lapx * kx;
      py_full = lapy * ky;
   end

   always_ff @(posedge clock) begin
      if (enable && b_emit_ff) begin
         c_ctr_ff  <= w1_1_ff;
         c_px_ff   <= $signed(px_full[PROD-1:FRAC_BITS]);
         c_py_ff   <= $signed(py_full[PROD-1:FRAC_BITS]);
         c_row_ff  <= b_row_ff;
         c_col_ff  <= b_col_ff;
         c_last_ff <= b_last_ff;
      end
   end

   // stage D: sum and saturate
   always_comb begin
      sum = $signed(SW'(c_ctr_ff)) + SW'(c_px_ff) + SW'(c_py_ff);
      if (sum[SW-1]) begin
         sat = '0;
      end else if (sum[SW-2:TEMP_BITS] != '0) begin
         sat = '1;
      end else begin
         sat = sum[TEMP_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (enable && c_emit_ff) begin
         rsp_temp_ff <= sat;
         rsp_row_ff  <= c_row_ff;
         rsp_col_ff  <= c_col_ff;
         rsp_last_ff <= c_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({rsp_col_ff, rsp_row_ff, rsp_temp_ff});
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: hw/rtl/hds_checker.sv
// Port-level checks for the heat diffusion stencil, bound to the top level.
`include "heat_diffusion_stencil_defines.svh"
module hds_checker import hds_pkg::*; #(
   parameter int MAX_WIDTH = 1024,
   parameter int TEMP_BITS = 32,
   localparam int COL_BITS      = $clog2(MAX_WIDTH),
   localparam int REQ_DATA_BITS = ((TEMP_BITS + 7) / 8) * 8,
   localparam int RSP_DATA_BITS = ((TEMP_BITS + ROW_BITS + COL_BITS + 7) / 8) * 8
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic [REQ_DATA_BITS-1:0]  req_tdata,   // temperature
   input logic                      req_tuser,   // first_point
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [RSP_DATA_BITS-1:0]  rsp_tdata,   // new_temperature, out_row, out_col
   input logic                      rsp_tlast,   // last_point
   input logic                      csr_valid,
   input logic                      csr_ready,
   input logic [CSR_INDEX_BITS-1:0] csr_index,
   input logic [CSR_DATA_BITS-1:0]  csr_data
);

   logic [ROW_BITS-1:0] rsp_row;
   logic [COL_BITS-1:0] rsp_col;
   logic                rsp_stall;

   assign rsp_row   = rsp_tdata[TEMP_BITS +: ROW_BITS];
   assign rsp_col   = rsp_tdata[TEMP_BITS + ROW_BITS +: COL_BITS];
   assign rsp_stall = rsp_tvalid && !rsp_tready;

   // hold a stalled result word
   `HDS_ASSERT_NEXT(rsp_hold_a, rsp_stall, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled result word changed")

   // no point of row 0 or column 0 leaves the block
   `HDS_ASSERT_SAME(rsp_interior_a, rsp_tvalid, (rsp_row != '0) && (rsp_col != '0), "boundary point emitted")

   // with an empty output stage the input side must take words
   `HDS_ASSERT_SAME(req_ready_a, !rsp_tvalid, req_tready, "input stalled with empty output")

   // a stalled receiver holds the input side too
   `HDS_ASSERT_SAME(req_stall_a, rsp_stall, !req_tready, "input taken while output stalled")

endmodule

bind heat_diffusion_stencil hds_checker #(
   .MAX_WIDTH(MAX_WIDTH),
   .TEMP_BITS(TEMP_BITS)
) u_hds_checker (.*);

// File: verif/tb_heat_diffusion_stencil.sv
// Self-checking testbench for the heat diffusion stencil: default grid, directed grids, random phases, wide grid.
module tb_heat_diffusion_stencil;
   import hds_pkg::*;

   localparam int GRID_MAX_COLS = 1024;
   localparam int TEMP_WIDTH    = 32;
   localparam int REQ_BITS      = ((TEMP_WIDTH + 7) / 8) * 8;
   localparam int RSP_BITS      = ((TEMP_WIDTH + ROW_BITS + 10 + 7) / 8) * 8;
   localparam int RANDOM_WORDS  = 1500;
   localparam int DRAIN_CYCLES  = 8;
   localparam int QUIET_LIMIT   = 1000;
   localparam int MAX_REPORTS   = 10;

   localparam logic [31:0] TEMP_MAX  = 32'hFFFF_FFFF;
   localparam longint      TEMP_CEIL = 64'd4294967295;

   typedef struct packed {
      logic [31:0] temp;
      logic [15:0] row;
      logic [9:0]  col;
      logic        last;
   } cell_update_t;

   typedef enum logic [1:0] {
      ROW_PREDICTED,
      ROW_SILENT,
      ROW_GIVEN
   } row_kind_t;

   typedef struct packed {
      logic [31:0]  temp;
      logic         first;
      row_kind_t    kind;
      cell_update_t want;
   } stencil_row_t;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PERIODIC,
      STALL_BURST
   } stall_mode_t;

   localparam cell_update_t NO_UPDATE      = '0;
   localparam cell_update_t SATURATED_HIGH = '{TEMP_MAX, 16'd1, 10'd1, 1'b1};
   localparam cell_update_t SATURATED_LOW  = '{32'd0, 16'd1, 10'd1, 1'b1};

   // Both 3x3 grids run with both coefficients at full scale.
   localparam stencil_row_t DIRECTED_ROWS [0:18] = '{
      // abandoned after one word, restarted by the next
      '{32'h5A5A_A5A5, 1'b1, ROW_PREDICTED, NO_UPDATE},
      // cold center among hot neighbors: overshoots above full scale
      '{TEMP_MAX, 1'b1, ROW_SILENT, NO_UPDATE},
      '{TEMP_MAX, 1'b0, ROW_SILENT, NO_UPDATE},
      '{TEMP_MAX, 1'b0, ROW_SILENT, NO_UPDATE},
      '{TEMP_MAX, 1'b0, ROW_SILENT, NO_UPDATE},
      '{32'd0,    1'b0, ROW_SILENT, NO_UPDATE},
      '{TEMP_MAX, 1'b0, ROW_SILENT, NO_UPDATE},
      '{TEMP_MAX, 1'b0, ROW_SILENT, NO_UPDATE},
      '{TEMP_MAX, 1'b0, ROW_SILENT, NO_UPDATE},
      '{TEMP_MAX, 1'b0, ROW_GIVEN,  SATURATED_HIGH},
      // next grid follows the wrap without a start marker; hot center undershoots zero
      '{32'd0,    1'b0, ROW_SILENT, NO_UPDATE},
      '{32'd0,    1'b0, ROW_SILENT, NO_UPDATE},
      '{32'd0,    1'b0, ROW_SILENT, NO_UPDATE},
      '{32'd0,    1'b0, ROW_SILENT, NO_UPDATE},
      '{TEMP_MAX, 1'b0, ROW_SILENT, NO_UPDATE},
      '{32'd0,    1'b0, ROW_SILENT, NO_UPDATE},
      '{32'd0,    1'b0, ROW_SILENT, NO_UPDATE},
      '{32'd0,    1'b0, ROW_SILENT, NO_UPDATE},
      '{32'd0,    1'b0, ROW_GIVEN,  SATURATED_LOW}
   };

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_BITS-1:0]       req_tdata;   // temperature
   logic                      req_tuser;   // first_point
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_BITS-1:0]       rsp_tdata;   // new_temperature, out_row, out_col
   logic                      rsp_tlast;   // last_point
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;

   // stencil predictor state
   logic [GRID_WIDTH_BITS-1:0] cfg_width;
   logic [ROW_BITS-1:0]        cfg_height;
   logic [COEF_BITS-1:0]       cfg_coef_x;
   logic [COEF_BITS-1:0]       cfg_coef_y;
   logic [31:0]                older_row [GRID_MAX_COLS];
   logic [31:0]                newer_row [GRID_MAX_COLS];
   logic [31:0]                patch [0:2][0:2];
   int                         col_pos;
   int                         row_pos;

   cell_update_t due_updates [$];
   int           bad_updates  = 0;
   int           quiet_cycles = 0;
   int           words_sent   = 0;
   int           burst_left   = 0;
   logic [31:0]  temp_base;

   heat_diffusion_stencil #(
      .MAX_WIDTH (GRID_MAX_COLS),
      .TEMP_BITS (TEMP_WIDTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int eff_width();
      int w;
      w = cfg_width;
      if (w < 3) w = 3;
      if (w > GRID_MAX_COLS) w = GRID_MAX_COLS;
      return w;
   endfunction

   function automatic int eff_height();
      int h;
      h = cfg_height;
      if (h < 3) h = 3;
      return h;
   endfunction

   function automatic logic [COEF_BITS-1:0] pick_coef();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return COEF_BITS'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [31:0] pick_temperature();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return TEMP_MAX;
         2, 3: return $urandom;
         default: return temp_base + $urandom_range(0, 20'hFFFFF);
      endcase
   endfunction

   // Advance the predicted grid position by one word and form the update it releases.
   task automatic step_stencil(input logic [31:0] temp, input logic first,
                               output bit emits, output cell_update_t upd);
      int     w, h, r, c, k;
      longint centre, lft, rgt, up, dn, kx, ky, lap_x, lap_y, level;
      w = eff_width();
      h = eff_height();
      if (first) begin
         col_pos = 0;
         row_pos = 0;
      end
      r = row_pos;
      c = col_pos;
      if (c >= GRID_MAX_COLS) c = GRID_MAX_COLS - 1;
      for (k = 0; k < 3; k++) begin
         patch[k][0] = patch[k][1];
         patch[k][1] = patch[k][2];
      end
      patch[0][2] = older_row[c];
      patch[1][2] = newer_row[c];
      patch[2][2] = temp;
      older_row[c] = newer_row[c];
      newer_row[c] = temp;

      emits = (r >= 2) && (r <= h - 1) && (c >= 2) && (c <= w - 1);
      upd = NO_UPDATE;
      if (emits) begin
         centre = patch[1][1];
         lft = patch[1][0];
         rgt = patch[1][2];
         up = patch[0][1];
         dn = patch[2][1];
         kx = cfg_coef_x;
         ky = cfg_coef_y;
         lap_x = lft + rgt - 2 * centre;
         lap_y = up + dn - 2 * centre;
         // arithmetic shift floors the scaled terms toward minus infinity
         level = centre + ((lap_x * kx) >>> FRAC_BITS) + ((lap_y * ky) >>> FRAC_BITS);
         if (level < 0) level = 0;
         else if (level > TEMP_CEIL) level = TEMP_CEIL;
         upd.temp = level[31:0];
         upd.row = ROW_BITS'(r - 1);
         upd.col = 10'(c - 1);
         upd.last = (r == h - 1) && (c == w - 1);
      end

      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endtask

   task automatic send_point(input logic [31:0] temp, input logic first,
                             input row_kind_t kind, input cell_update_t given);
      int           gap;
      bit           emits;
      cell_update_t upd;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(150, 400)
                                                 : $urandom_range(1, 48);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= temp;
      req_tuser <= first;
      do @(posedge clock); while (!req_tready);
      step_stencil(temp, first, emits, upd);
      case (kind)
         ROW_PREDICTED: if (emits) due_updates.push_back(upd);
         ROW_GIVEN: due_updates.push_back(given);
         default: ;
      endcase
      words_sent++;
   endtask

   // Hold until every update is out and the pipeline has had time to empty.
   task automatic wait_idle();
      int ready_cycles;
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (due_updates.size() != 0) @(posedge clock);
      ready_cycles = 0;
      while (ready_cycles < DRAIN_CYCLES) begin
         @(posedge clock);
         if (rsp_tready) ready_cycles++;
      end
   endtask

   task automatic write_config(input logic [GRID_WIDTH_BITS-1:0] w, input logic [15:0] h,
                               input logic [15:0] kx, input logic [15:0] ky);
      csr_reg_type order [4];
      logic [15:0] value;
      order = '{REG_GRID_WIDTH, REG_GRID_HEIGHT, REG_COEF_X, REG_COEF_Y};
      foreach (order[n]) begin
         case (order[n])
            REG_GRID_WIDTH:  value = 16'(w);
            REG_GRID_HEIGHT: value = h;
            REG_COEF_X:      value = kx;
            default:         value = ky;
         endcase
         csr_valid <= 1'b1;
         csr_index <= order[n];
         csr_data <= value;
         do @(posedge clock); while (!csr_ready);
         case (order[n])
            REG_GRID_WIDTH:  cfg_width = value[GRID_WIDTH_BITS-1:0];
            REG_GRID_HEIGHT: cfg_height = value;
            REG_COEF_X:      cfg_coef_x = value;
            default:         cfg_coef_y = value;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // Stream whole grids; a grid taller than row_cap, or one cut at random, ends short and the next one restarts.
   task automatic stream_grids(input int grids, input int row_cap);
      int ew, eh, rows, count, g, i;
      bit restart, partial;
      ew = eff_width();
      eh = eff_height();
      temp_base = $urandom;
      restart = 1'b1;
      for (g = 0; g < grids; g++) begin
         rows = (eh > row_cap) ? row_cap : eh;
         count = ew * rows;
         partial = eh > row_cap;
         if (!partial && g + 1 < grids && $urandom_range(0, 3) == 0) begin
            count = $urandom_range(1, count - 1);
            partial = 1'b1;
         end
         for (i = 0; i < count; i++) begin
            send_point(pick_temperature(), (i == 0) && (restart || $urandom_range(0, 1)),
                       ROW_PREDICTED, NO_UPDATE);
         end
         restart = partial;
      end
   endtask

   task automatic run_phase(input logic [GRID_WIDTH_BITS-1:0] w, input logic [15:0] h,
                            input int grids, input int row_cap);
      wait_idle();
      write_config(w, h, pick_coef(), pick_coef());
      stream_grids(grids, row_cap);
   endtask

   // receiver: ready pattern changes mode every so often
   initial begin
      stall_mode_t mode;
      int          span, period, hold, step;
      rsp_tready <= 1'b0;
      forever begin
         mode = stall_mode_t'($urandom_range(0, 3));
         span = $urandom_range(20, 200);
         period = $urandom_range(2, 5);
         hold = $urandom_range(5, 25);
         for (step = 0; step < span; step++) begin
            @(posedge clock);
            case (mode)
               STALL_NONE:     rsp_tready <= 1'b1;
               STALL_RANDOM:   rsp_tready <= 1'($urandom_range(0, 1));
               STALL_PERIODIC: rsp_tready <= (step % period) != 0;
               default:        rsp_tready <= step >= hold;
            endcase
         end
      end
   end

   always @(posedge clock) begin : check_updates
      cell_update_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[31:0], rsp_tdata[47:32], rsp_tdata[57:48], rsp_tlast};
         if (due_updates.size() == 0) begin
            bad_updates++;
            if (bad_updates <= MAX_REPORTS)
               $display("unexpected update: temp %h row %0d col %0d last %0d",
                        got.temp, got.row, got.col, got.last);
         end else begin
            want = due_updates.pop_front();
            if (got.temp !== want.temp || got.row !== want.row ||
                got.col !== want.col || got.last !== want.last) begin
               bad_updates++;
               if (bad_updates <= MAX_REPORTS)
                  $display("update mismatch: expected temp %h row %0d col %0d last %0d, %s",
                           want.temp, want.row, want.col, want.last,
                           $sformatf("got temp %h row %0d col %0d last %0d",
                                     got.temp, got.row, got.col, got.last));
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int n, w0, h0, count, i;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= REG_GRID_WIDTH;
      csr_data <= '0;
      cfg_width = GRID_WIDTH_RESET;
      cfg_height = GRID_HEIGHT_RESET;
      cfg_coef_x = '0;
      cfg_coef_y = '0;
      col_pos = 0;
      row_pos = 0;
      patch = '{default: '0};
      for (n = 0; n < GRID_MAX_COLS; n++) begin
         older_row[n] = '0;
         newer_row[n] = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // register defaults: full-width rows, zero coefficients pass the center through
      stream_grids(1, 3);

      wait_idle();
      write_config(11'd3, 16'd3, 16'hFFFF, 16'hFFFF);
      for (n = 0; n < $size(DIRECTED_ROWS); n++)
         send_point(DIRECTED_ROWS[n].temp, DIRECTED_ROWS[n].first,
                    DIRECTED_ROWS[n].kind, DIRECTED_ROWS[n].want);

      words_sent = 0;
      while (words_sent < RANDOM_WORDS) begin
         case ($urandom_range(0, 9))
            0: run_phase($urandom_range(0, 1) ? 11'($urandom_range(0, 2))
                                              : 11'($urandom_range(3, 8)),
                         $urandom_range(0, 1) ? 16'($urandom_range(0, 2))
                                              : 16'($urandom_range(3, 6)),
                         $urandom_range(1, 3), 64);
            1: run_phase(11'($urandom_range(3, 6)), 16'hFFFF, 1, 12);
            2: begin
               // shrink the width in the middle of a grid and carry on without a restart
               w0 = $urandom_range(6, 12);
               h0 = $urandom_range(4, 8);
               wait_idle();
               write_config(11'(w0), 16'(h0), pick_coef(), pick_coef());
               temp_base = $urandom;
               count = $urandom_range(1, w0 * h0 - 1);
               for (i = 0; i < count; i++)
                  send_point(pick_temperature(), i == 0, ROW_PREDICTED, NO_UPDATE);
               wait_idle();
               write_config(11'($urandom_range(3, w0 - 1)), 16'($urandom_range(3, 8)),
                            pick_coef(), pick_coef());
               count = eff_width() * eff_height() * 2 + $urandom_range(0, 5);
               for (i = 0; i < count; i++)
                  send_point(pick_temperature(), 1'b0, ROW_PREDICTED, NO_UPDATE);
            end
            default: run_phase(($urandom_range(0, 7) == 0) ? 11'($urandom_range(13, 40))
                                                           : 11'($urandom_range(3, 12)),
                               16'($urandom_range(3, 8)), $urandom_range(1, 3), 64);
         endcase
      end

      // width register beyond the line buffer clamps to the full buffer
      run_phase(11'd2047, 16'd3, 1, 3);

      req_tvalid <= 1'b0;
      while (due_updates.size() != 0) @(posedge clock);
      repeat (4 * DRAIN_CYCLES) @(posedge clock);
      if (bad_updates == 0 && due_updates.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
